// ===== src/csr_sparse_matvec_defines.svh =====
// Assertion macros for the sparse matrix-vector block.
`ifndef CSR_SPARSE_MATVEC_DEFINES_SVH
`define CSR_SPARSE_MATVEC_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSR_SMV_ASSERT_IMPLY(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CSR_SMV_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/csr_smv_pkg.sv =====
// Shared constants and types for the sparse matrix-vector block.
package csr_smv_pkg;

	localparam int VEC_DEPTH = 4096;
	localparam int ADDR_W    = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
	localparam int IDX_W     = 12;
	localparam int VAL_W     = 32;
	localparam int ACC_W     = 64;
	localparam int ROW_W     = 12;
	localparam int CMP_W     = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

	typedef enum logic [1:0] {
		FUNC_LOAD    = 2'd0,
		FUNC_NZ      = 2'd1,
		FUNC_EMPTY   = 2'd2,
		FUNC_RESTART = 2'd3
	} func_t;

	typedef struct packed {
		func_t func;
		logic  last;
	} ctl_t;

endpackage

// ===== src/csr_smv_vstore.sv =====
// Vector store memory and first pipeline stage: write on load, read on nonzero.
module csr_smv_vstore (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          func,
	input  logic [csr_smv_pkg::IDX_W-1:0]       index,
	input  logic signed [csr_smv_pkg::VAL_W-1:0] value,
	input  logic                                row_end,
	input  logic                                s1_adv,
	output logic                                s1_valid,
	output csr_smv_pkg::ctl_t                   ctl_s1,
	output logic signed [csr_smv_pkg::VAL_W-1:0] value_s1,
	output logic signed [csr_smv_pkg::VAL_W-1:0] x_s1
);
	import csr_smv_pkg::*;

	logic [VAL_W-1:0]  mem [VEC_DEPTH];
	logic [VAL_W-1:0]  rdata_s1;
	logic              hit_s1;
	logic              valid_s1;
	logic              accept;
	logic              in_range;
	logic [ADDR_W-1:0] addr;
	func_t             func_in;

	assign func_in  = func_t'(func);
	assign in_range = CMP_W'(index) < CMP_W'(VEC_DEPTH);
	assign addr     = ADDR_W'(index);
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (accept && func_in == FUNC_LOAD && in_range) begin
			mem[addr] <= value;
		end
		if (accept) begin
			rdata_s1 <= mem[addr];
			hit_s1   <= in_range;
			value_s1 <= value;
			ctl_s1   <= '{func: func_in, last: row_end};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (func_in != FUNC_LOAD);
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	assign s1_valid = valid_s1;
	assign x_s1     = hit_s1 ? signed'(rdata_s1) : '0;

endmodule

// ===== src/csr_smv_mac.sv =====
// Multiply stage, saturating accumulator and row counter.
module csr_smv_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s1_valid,
	input  csr_smv_pkg::ctl_t                    ctl_s1,
	input  logic signed [csr_smv_pkg::VAL_W-1:0] value_s1,
	input  logic signed [csr_smv_pkg::VAL_W-1:0] x_s1,
	output logic                                 s1_adv,
	input  logic                                 s3_take,
	output logic                                 s3_valid,
	output logic [csr_smv_pkg::ROW_W-1:0]        row_s3,
	output logic signed [csr_smv_pkg::ACC_W-1:0] sum_s3,
	output logic                                 empty_s3
);
	import csr_smv_pkg::*;

	logic signed [ACC_W-1:0] prod_s2;
	ctl_t                    ctl_s2;
	logic                    valid_s2;
	logic                    valid_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic [ROW_W-1:0]        row_q;
	logic signed [ACC_W:0]   raw_sum;
	logic signed [ACC_W-1:0] sat_sum;
	logic                    ovf;
	logic                    emits;
	logic                    s3_free;
	logic                    s2_go;

	assign raw_sum = {acc_q[ACC_W-1], acc_q} + {prod_s2[ACC_W-1], prod_s2};
	assign ovf     = (acc_q[ACC_W-1] == prod_s2[ACC_W-1])
		&& (raw_sum[ACC_W-1] != acc_q[ACC_W-1]);
	assign sat_sum = ovf ? (acc_q[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
		: {1'b0, {(ACC_W-1){1'b1}}}) : raw_sum[ACC_W-1:0];

	assign emits   = (ctl_s2.func == FUNC_EMPTY) || (ctl_s2.func == FUNC_NZ && ctl_s2.last);
	assign s3_free = !valid_s3 || s3_take;
	assign s2_go   = valid_s2 && (!emits || s3_free);
	assign s1_adv  = !valid_s2 || s2_go;

	always_ff @(posedge clk) begin
		if (s1_valid && s1_adv) begin
			prod_s2 <= value_s1 * x_s1;
			ctl_s2  <= ctl_s1;
		end
		if (s2_go && emits) begin
			row_s3   <= row_q;
			sum_s3   <= sat_sum;
			empty_s3 <= (ctl_s2.func == FUNC_EMPTY);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			acc_q    <= '0;
			row_q    <= '0;
		end else begin
			if (s1_adv) begin
				valid_s2 <= s1_valid;
			end
			if (s2_go && emits) begin
				valid_s3 <= 1'b1;
			end else if (s3_take) begin
				valid_s3 <= 1'b0;
			end
			if (s2_go) begin
				case (ctl_s2.func)
					FUNC_NZ: begin
						acc_q <= ctl_s2.last ? '0 : sat_sum;
						if (ctl_s2.last) begin
							row_q <= row_q + 1'b1;
						end
					end
					FUNC_EMPTY: begin
						acc_q <= '0;
						row_q <= row_q + 1'b1;
					end
					FUNC_RESTART: begin
						acc_q <= '0;
						row_q <= '0;
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end
		end
	end

	assign s3_valid = valid_s3;

endmodule

// ===== src/csr_smv_out.sv =====
// Rounding, clipping and output register.
module csr_smv_out (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s3_valid,
	input  logic [csr_smv_pkg::ROW_W-1:0]        row_s3,
	input  logic signed [csr_smv_pkg::ACC_W-1:0] sum_s3,
	input  logic                                 empty_s3,
	output logic                                 s3_take,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [csr_smv_pkg::ROW_W-1:0]        row,
	output logic signed [csr_smv_pkg::VAL_W-1:0] y_value,
	output logic                                 saturated
);
	import csr_smv_pkg::*;

	localparam int RND_W = ACC_W - 16 + 1;

	logic                    valid_q;
	logic signed [RND_W-1:0] rounded;
	logic signed [VAL_W-1:0] clipped;
	logic                    hi;
	logic                    lo;

	assign rounded = {sum_s3[ACC_W-1], sum_s3[ACC_W-1:16]} + RND_W'(sum_s3[15]);
	assign hi      = rounded > RND_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}));
	assign lo      = rounded < -(RND_W'(signed'({1'b0, 1'b1, {(VAL_W-1){1'b0}}})));
	assign clipped = hi ? {1'b0, {(VAL_W-1){1'b1}}}
		: lo ? {1'b1, {(VAL_W-1){1'b0}}} : rounded[VAL_W-1:0];

	assign s3_take = s3_valid && (!valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (s3_take) begin
			row       <= row_s3;
			y_value   <= empty_s3 ? '0 : clipped;
			saturated <= !empty_s3 && (hi || lo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s3_take) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;

endmodule

// ===== src/csr_sparse_matvec.sv =====
// Top level of the sparse matrix times dense vector block.
//  channel | dir | handshake           | beat payload
//  in      | in  | in_valid, in_stall  | func, index, value, row_end
//  out     | out | out_valid, out_stall | row, y_value, saturated
// One beat per cycle sustained while out_stall is low; each load, nonzero, empty row or
// restart is a single beat. A beat passes the registered stages memory read, multiply,
// accumulate, round and clip into the output register.
// Reset clears the pipeline valids, accumulator and row counter; the vector store is not cleared.
// An output stall backs up stage by stage; input stalls only when every stage is full.
module csr_sparse_matvec (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           func,
	input  logic [csr_smv_pkg::IDX_W-1:0]        index,
	input  logic signed [csr_smv_pkg::VAL_W-1:0] value,
	input  logic                                 row_end,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [csr_smv_pkg::ROW_W-1:0]        row,
	output logic signed [csr_smv_pkg::VAL_W-1:0] y_value,
	output logic                                 saturated
);
	import csr_smv_pkg::*;

	`include "csr_sparse_matvec_defines.svh"

	logic                    s1_valid;
	logic                    s1_adv;
	ctl_t                    ctl_s1;
	logic signed [VAL_W-1:0] value_s1;
	logic signed [VAL_W-1:0] x_s1;
	logic                    s3_valid;
	logic                    s3_take;
	logic [ROW_W-1:0]        row_s3;
	logic signed [ACC_W-1:0] sum_s3;
	logic                    empty_s3;

	csr_smv_vstore u_vstore (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.index    (index),
		.value    (value),
		.row_end  (row_end),
		.s1_adv   (s1_adv),
		.s1_valid (s1_valid),
		.ctl_s1   (ctl_s1),
		.value_s1 (value_s1),
		.x_s1     (x_s1)
	);

	csr_smv_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.ctl_s1   (ctl_s1),
		.value_s1 (value_s1),
		.x_s1     (x_s1),
		.s1_adv   (s1_adv),
		.s3_take  (s3_take),
		.s3_valid (s3_valid),
		.row_s3   (row_s3),
		.sum_s3   (sum_s3),
		.empty_s3 (empty_s3)
	);

	csr_smv_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.s3_valid  (s3_valid),
		.row_s3    (row_s3),
		.sum_s3    (sum_s3),
		.empty_s3  (empty_s3),
		.s3_take   (s3_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.row       (row),
		.y_value   (y_value),
		.saturated (saturated)
	);

	`CSR_SMV_ASSERT_IMPLY(a_stall_needs_full_out, in_stall, out_valid && out_stall && s3_valid, "input stalled while output side can drain")

	`CSR_SMV_ASSERT_IMPLY(a_sat_at_limit, out_valid && saturated, y_value == 32'sh7fffffff || y_value == 32'sh80000000, "saturated flag without a clipped value")

	`CSR_SMV_ASSERT_NEXT(a_s3_held, s3_valid && !s3_take, s3_valid && $stable(sum_s3) && $stable(row_s3), "pending row sum lost while output stalled")

endmodule
